### hw/rtl/ipcc_pkg.sv
// Package with the shared types, constants and helper functions of the checksum checker.
`timescale 1ns / 1ps
package ipcc_pkg;

	localparam int DEF_MAX_PACKET_BYTES = 65535;
	localparam int DEF_QUEUE_DEPTH      = 4;

	localparam logic [2:0] KIND_ICMP  = 3'd0;
	localparam logic [2:0] KIND_IGMP  = 3'd1;
	localparam logic [2:0] KIND_TCP   = 3'd2;
	localparam logic [2:0] KIND_UDP   = 3'd3;
	localparam logic [2:0] KIND_ICMP6 = 3'd4;

	localparam logic [7:0] PROTO_ICMP  = 8'd1;
	localparam logic [7:0] PROTO_IGMP  = 8'd2;
	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] PROTO_ICMP6 = 8'd58;
	localparam logic [7:0] PROTO_EIGRP = 8'd88;

	localparam logic [3:0] IPV6_VERSION = 4'd6;
	localparam logic [7:0] IPV6_HDR_LEN = 8'd40;
	localparam logic [7:0] MIN_V4_HDR   = 8'd20;

	typedef struct packed {
		logic       known;
		logic [2:0] kind;
	} kind_info_t;

	// Summary of one packet, handed from the parser to the checksum pipeline.
	typedef struct packed {
		logic        known;
		logic [2:0]  kind;
		logic        v6;
		logic        frag;
		logic [7:0]  hdr_len;
		logic [15:0] pay_len;
		logic [15:0] byte_count;
		logic [31:0] sum;
		logic [7:0]  proto;
		logic [15:0] udp_len;
		logic [15:0] cks;
	} pkt_rec_t;

	function automatic kind_info_t kind_lookup(input logic [7:0] proto, input logic v6);
		kind_info_t k;
		k.known = 1'b1;
		k.kind  = KIND_ICMP;
		case (proto)
			PROTO_ICMP:               k.kind = KIND_ICMP;
			PROTO_IGMP, PROTO_EIGRP:  k.kind = KIND_IGMP;
			PROTO_TCP:                k.kind = KIND_TCP;
			PROTO_UDP:                k.kind = KIND_UDP;
			PROTO_ICMP6: begin
				k.kind  = KIND_ICMP6;
				k.known = v6;
			end
			default:                  k.known = 1'b0;
		endcase
		return k;
	endfunction

	// Offset of the checksum field within the transport header.
	function automatic logic [4:0] cksum_off(input logic [2:0] kind);
		logic [4:0] r;
		case (kind)
			KIND_TCP: r = 5'd16;
			KIND_UDP: r = 5'd6;
			default:  r = 5'd2;
		endcase
		return r;
	endfunction

	function automatic logic uses_pseudo(input kind_info_t k);
		return k.known && (k.kind == KIND_TCP || k.kind == KIND_UDP || k.kind == KIND_ICMP6);
	endfunction

endpackage

### hw/rtl/ipcc_front.sv
// Byte parser: tracks the IP header, accumulates the raw sum and emits one record per packet.
`timescale 1ns / 1ps
module ipcc_front #(
	parameter int MAX_PACKET_BYTES = ipcc_pkg::DEF_MAX_PACKET_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               rec_push,
	output ipcc_pkg::pkt_rec_t rec
);
	import ipcc_pkg::*;

	localparam logic [15:0] MAX_POS = 16'(MAX_PACKET_BYTES);

	logic [15:0] pos_q, pos_inc;
	logic [3:0]  ver_q, ver_d;
	logic [7:0]  hl_q, hl_d;
	logic [15:0] plen_q, plen_d;
	logic [7:0]  proto_q, proto_d;
	logic        frag_q, frag_d;
	logic [31:0] sum_q, sum_d;
	logic [7:0]  pend_q, pend_d;
	logic [15:0] cks_q, cks_d;
	logic [15:0] udp_q, udp_d;
	logic        take, v6, add_en;
	logic [15:0] off;
	logic [15:0] ck;
	logic [31:0] addend;
	kind_info_t  kinfo;

	assign take    = pos_q < MAX_POS;
	assign v6      = ver_q == IPV6_VERSION;
	assign kinfo   = kind_lookup(proto_q, v6);
	assign off     = pos_q - {8'd0, hl_q};
	assign ck      = {11'd0, cksum_off(kinfo.kind)};
	assign pos_inc = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;

	always_comb begin
		ver_d   = ver_q;
		hl_d    = hl_q;
		plen_d  = plen_q;
		proto_d = proto_q;
		frag_d  = frag_q;
		pend_d  = pend_q;
		cks_d   = cks_q;
		udp_d   = udp_q;
		add_en  = 1'b0;
		if (take) begin
			if (pos_q == 16'd0) begin
				ver_d = data_byte[7:4];
				hl_d  = (data_byte[7:4] == IPV6_VERSION) ? IPV6_HDR_LEN
				                                         : {2'b00, data_byte[3:0], 2'b00};
			end else begin
				if (!v6) begin
					if (pos_q == 16'd2) begin
						pend_d = data_byte;
					end else if (pos_q == 16'd3) begin
						plen_d = {pend_q, data_byte} - {8'd0, hl_q};
					end else if (pos_q == 16'd6) begin
						if (data_byte[5] || data_byte[4:0] != 5'd0) frag_d = 1'b1;
					end else if (pos_q == 16'd7) begin
						if (data_byte != 8'd0) frag_d = 1'b1;
					end else if (pos_q == 16'd9) begin
						proto_d = data_byte;
					end else if (pos_q >= 16'd12 && pos_q <= 16'd19 && uses_pseudo(kinfo)) begin
						add_en = 1'b1;
					end
				end else begin
					if (pos_q == 16'd4) begin
						pend_d = data_byte;
					end else if (pos_q == 16'd5) begin
						plen_d = {pend_q, data_byte};
					end else if (pos_q == 16'd6) begin
						proto_d = data_byte;
					end else if (pos_q >= 16'd8 && pos_q <= 16'd39 && uses_pseudo(kinfo)) begin
						add_en = 1'b1;
					end
				end
				// Header lengths are even, so payload byte parity equals position parity.
				if ((v6 || hl_q >= MIN_V4_HDR) && pos_q >= {8'd0, hl_q} && off < plen_q) begin
					add_en = 1'b1;
					if (off == ck) begin
						cks_d = {data_byte, cks_q[7:0]};
					end else if (off == ck + 16'd1) begin
						cks_d = {cks_q[15:8], data_byte};
					end
					if (off == 16'd4) begin
						udp_d = {data_byte, udp_q[7:0]};
					end else if (off == 16'd5) begin
						udp_d = {udp_q[15:8], data_byte};
					end
				end
			end
		end
		addend = !add_en ? 32'd0 : (pos_q[0] ? {24'd0, data_byte} : {16'd0, data_byte, 8'd0});
		sum_d  = sum_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ver_q   <= '0;
			hl_q    <= '0;
			plen_q  <= '0;
			proto_q <= '0;
			frag_q  <= 1'b0;
			sum_q   <= '0;
			pend_q  <= '0;
			cks_q   <= '0;
			udp_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q   <= '0;
				ver_q   <= '0;
				hl_q    <= '0;
				plen_q  <= '0;
				proto_q <= '0;
				frag_q  <= 1'b0;
				sum_q   <= '0;
				pend_q  <= '0;
				cks_q   <= '0;
				udp_q   <= '0;
			end else begin
				pos_q   <= pos_inc;
				ver_q   <= ver_d;
				hl_q    <= hl_d;
				plen_q  <= plen_d;
				proto_q <= proto_d;
				frag_q  <= frag_d;
				sum_q   <= sum_d;
				pend_q  <= pend_d;
				cks_q   <= cks_d;
				udp_q   <= udp_d;
			end
		end
	end

	kind_info_t kfin;
	assign kfin = kind_lookup(proto_d, ver_d == IPV6_VERSION);

	assign rec_push       = accept && last_byte;
	assign rec.known      = kfin.known;
	assign rec.kind       = kfin.kind;
	assign rec.v6         = ver_d == IPV6_VERSION;
	assign rec.frag       = frag_d;
	assign rec.hdr_len    = hl_d;
	assign rec.pay_len    = plen_d;
	assign rec.byte_count = (pos_inc < MAX_POS) ? pos_inc : MAX_POS;
	assign rec.sum        = sum_d;
	assign rec.proto      = proto_d;
	assign rec.udp_len    = udp_d;
	assign rec.cks        = cks_d;

endmodule

### hw/rtl/ipcc_queue.sv
// Small register queue of packet records between the parser and the checksum pipeline.
`timescale 1ns / 1ps
module ipcc_queue #(
	parameter int DEPTH = ipcc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  ipcc_pkg::pkt_rec_t wr_rec,
	input  logic               rd_en,
	output ipcc_pkg::pkt_rec_t rd_rec,
	output logic               full,
	output logic               nonempty
);
	import ipcc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	pkt_rec_t        mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign rd_rec   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + PW'(1);
			end
			if (rd_en) begin
				rp_q <= (rp_q == LAST_IDX) ? '0 : rp_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### hw/rtl/ipcc_back.sv
// Checksum pipeline: validity checks, pseudo header add, folding and the final result register.
`timescale 1ns / 1ps
module ipcc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	input  ipcc_pkg::pkt_rec_t rec,
	output logic               rec_take,
	input  logic               pop,
	output logic               empty,
	output logic               checked,
	output logic [2:0]         checksum_kind,
	output logic [15:0]        stored_checksum,
	output logic [15:0]        computed_checksum
);
	import ipcc_pkg::*;

	logic        v_s1, v_s2, v_s3, v_out_q;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic        ok_s1, ok_s2, ok_s3;
	logic [2:0]  kind_s1, kind_s2, kind_s3;
	logic [15:0] c_s1, c_s2, c_s3;
	logic [31:0] sum_s1, t_s3;
	logic [15:0] f_s2;
	logic        ones_s3;

	kind_info_t  ki;
	logic [16:0] end_len;
	logic [4:0]  ck_end;
	logic        ok_d;
	logic [15:0] pl_len;
	logic [31:0] pseudo;
	logic [16:0] f1;
	logic [16:0] g1;
	logic [15:0] g2;

	assign rdy_out  = !v_out_q || pop;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign rec_take = rec_valid && rdy_s1;
	assign empty    = !v_out_q;

	assign ki.known = rec.known;
	assign ki.kind  = rec.kind;
	assign end_len  = {9'd0, rec.hdr_len} + {1'b0, rec.pay_len};
	assign ck_end   = cksum_off(rec.kind) + 5'd2;
	assign ok_d     = rec.known && !(!rec.v6 && (rec.frag || rec.hdr_len < MIN_V4_HDR))
	                  && !(end_len > {1'b0, rec.byte_count})
	                  && !(rec.pay_len < {11'd0, ck_end});
	assign pl_len   = (rec.v6 && rec.kind == KIND_UDP) ? rec.udp_len : rec.pay_len;
	assign pseudo   = uses_pseudo(ki) ? ({24'd0, rec.proto} + {16'd0, pl_len}) : 32'd0;

	// Two end-around folds bring any 32-bit value down to 16 bits.
	assign f1 = {1'b0, sum_s1[31:16]} + {1'b0, sum_s1[15:0]};
	assign g1 = {1'b0, t_s3[31:16]} + {1'b0, t_s3[15:0]};
	assign g2 = 16'({16'd0, g1[16]} + {1'b0, g1[15:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= rec_valid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_s3)  v_s3    <= v_s2;
			if (rdy_out) v_out_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ok_s1   <= ok_d;
			kind_s1 <= rec.kind;
			c_s1    <= rec.cks;
			sum_s1  <= rec.sum + pseudo;
		end
		if (rdy_s2) begin
			ok_s2   <= ok_s1;
			kind_s2 <= kind_s1;
			c_s2    <= c_s1;
			f_s2    <= 16'({16'd0, f1[16]} + {1'b0, f1[15:0]});
		end
		if (rdy_s3) begin
			ok_s3   <= ok_s2;
			kind_s3 <= kind_s2;
			c_s3    <= c_s2;
			ones_s3 <= f_s2 == 16'hFFFF;
			t_s3    <= {16'hFFFF, ~f_s2} - {16'd0, ~c_s2};
		end
		if (rdy_out) begin
			checked           <= ok_s3;
			checksum_kind     <= ok_s3 ? kind_s3 : 3'd0;
			stored_checksum   <= ok_s3 ? c_s3 : 16'd0;
			computed_checksum <= !ok_s3 ? 16'd0
			                     : ((ones_s3 || g2 == 16'd0) ? c_s3 : g2);
		end
	end

endmodule

### hw/rtl/ip_payload_checksum_check_unit.sv
// Top level of the IPv4/IPv6 transport checksum checker.
//
// Usage: packet bytes enter on the input queue port, starting with the IP
// version byte; last_byte marks the final byte. A byte transaction completes
// on a rising edge with push high and full low. One byte is taken every cycle
// as long as full stays low. After each packet's last byte one result appears
// on the result port: empty goes low and the result is removed by pop.
// The parser handles one byte per cycle and writes a summary of each packet
// into a four-entry record queue; a four-stage checksum pipeline drains that
// queue through stages s1, s2, s3 and the output register. Throughput is one
// byte per cycle while full is low; the pipeline retires one packet result per
// cycle while pop keeps up, so even one-byte packets stream back to back.
// When the receiver holds pop low the pipeline fills, then the record queue,
// and only then does full rise; bytes of a packet in progress are never lost.
// checked is 0 for fragments, unknown protocols, bad header lengths and short
// packets; kind and both checksum fields are then 0.
// Reset clears the parser, empties the queue and the pipeline; empty is high.
`timescale 1ns / 1ps
module ip_payload_checksum_check_unit #(
	parameter int MAX_PACKET_BYTES = ipcc_pkg::DEF_MAX_PACKET_BYTES,
	parameter int QUEUE_DEPTH      = ipcc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic        checked,
	output logic [2:0]  checksum_kind,
	output logic [15:0] stored_checksum,
	output logic [15:0] computed_checksum
);
	import ipcc_pkg::*;

	logic     accept;
	logic     rec_push, rec_take, rec_valid;
	pkt_rec_t rec_in, rec_out;

	// Bytes are held off only while the record queue is full.
	assign accept = push && !full;

	ipcc_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	ipcc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_push),
		.wr_rec   (rec_in),
		.rd_en    (rec_take),
		.rd_rec   (rec_out),
		.full     (full),
		.nonempty (rec_valid)
	);

	ipcc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.rec_valid         (rec_valid),
		.rec               (rec_out),
		.rec_take          (rec_take),
		.pop               (pop),
		.empty             (empty),
		.checked           (checked),
		.checksum_kind     (checksum_kind),
		.stored_checksum   (stored_checksum),
		.computed_checksum (computed_checksum)
	);

endmodule

### hw/rtl/ipcc_checker.sv
// Port-level assertions for the checksum checker, bound to the top level.
`timescale 1ns / 1ps
module ipcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        checked,
	input logic [2:0]  checksum_kind,
	input logic [15:0] stored_checksum,
	input logic [15:0] computed_checksum
);
	import ipcc_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result dropped while stalled");

	a_hold_value: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(computed_checksum) && $stable(stored_checksum))
		else $error("result changed while stalled");

	a_unchecked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !checked |-> checksum_kind == KIND_ICMP && stored_checksum == 16'd0
		&& computed_checksum == 16'd0) else $error("unchecked result not cleared");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && checked |-> checksum_kind <= KIND_ICMP6)
		else $error("kind code out of range");

endmodule

bind ip_payload_checksum_check_unit ipcc_checker u_ipcc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.empty             (empty),
	.pop               (pop),
	.checked           (checked),
	.checksum_kind     (checksum_kind),
	.stored_checksum   (stored_checksum),
	.computed_checksum (computed_checksum)
);
